// File: rtl/pfp_pkg.sv
package pfp_pkg;

    // Frame framing bytes and the reset value of the command register.
    localparam logic [7:0] HEADER_BYTE = 8'hAA;
    localparam logic [7:0] TAIL_BYTE   = 8'hAB;
    localparam logic [7:0] CMD_RESET   = 8'hC0;

    localparam int BYTE_W    = 8;
    localparam int RAW_W     = 16;
    localparam int READING_W = 13;
    localparam int POS_W     = 4;

    typedef logic [POS_W-1:0] t_pos;

    // Byte positions within a ten-byte frame.
    localparam t_pos POS_HEADER   = 4'd0;
    localparam t_pos POS_COMMAND  = 4'd1;
    localparam t_pos POS_SMALL_LO = 4'd2;
    localparam t_pos POS_SMALL_HI = 4'd3;
    localparam t_pos POS_LARGE_LO = 4'd4;
    localparam t_pos POS_LARGE_HI = 4'd5;
    localparam t_pos POS_SUM_LAST = 4'd7;
    localparam t_pos POS_CHECKSUM = 4'd8;
    localparam t_pos POS_TAIL     = 4'd9;

    // One result as it travels from the frame tracker to the output register.
    typedef struct packed {
        logic [READING_W-1:0] pm_small;
        logic [READING_W-1:0] pm_large;
        logic                 frame_accepted;
    } t_result;

endpackage

// File: rtl/particulate_frame_parser_core.sv
// Channel  | Direction | Handshake                   | Payload
// ---------+-----------+-----------------------------+--------------------------------------
// rx       | in        | i_rx_valid / o_rx_stall     | i_rx_byte
// res      | out       | o_res_valid / i_res_stall   | o_pm_small, o_pm_large,
//          |           |                             | o_frame_accepted
// cfg      | in        | i_cfg_valid / o_cfg_ready   | i_cfg_expected_command
//
// Each byte request is captured in the input register and then passes through the frame logic,
// so one byte is accepted every cycle while no frame-ending byte is held back. The result of a
// tenth byte is loaded into the output register as that byte leaves the input register.
// The per-frame work (checks, checksum, divide by ten via a reciprocal multiply) sits
// between the input register and the result register.
// Reset is synchronous and active low; it restarts framing at byte zero, clears the held
// readings and sets the command register to 0xC0.
// Only the tenth byte of a frame can be held back, and only while a result waits under
// stall; the other bytes keep flowing.
module particulate_frame_parser_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rx_valid,
    output logic                              o_rx_stall,
    input  logic [pfp_pkg::BYTE_W-1:0]        i_rx_byte,
    output logic                              o_res_valid,
    input  logic                              i_res_stall,
    output logic [pfp_pkg::READING_W-1:0]     o_pm_small,
    output logic [pfp_pkg::READING_W-1:0]     o_pm_large,
    output logic                              o_frame_accepted,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pfp_pkg::BYTE_W-1:0]        i_cfg_expected_command
);

    logic                         r_in_valid;
    logic [pfp_pkg::BYTE_W-1:0]   r_in_byte;
    logic [pfp_pkg::BYTE_W-1:0]   r_command;

    logic                         w_last;
    logic                         w_out_free;
    logic                         w_go;
    logic                         w_rx_accept;
    pfp_pkg::t_result             w_next_result;
    pfp_pkg::t_result             w_out_result;

    // The output register can take a new result when it is empty or drained this cycle.
    assign w_out_free  = !o_res_valid || !i_res_stall;
    // A byte that ends a frame needs room in the output register; others always proceed.
    assign w_go        = r_in_valid && (!w_last || w_out_free);
    assign o_rx_stall  = r_in_valid && !w_go;
    assign w_rx_accept = i_rx_valid && !o_rx_stall;

    // The command register is always writable.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_command  <= pfp_pkg::CMD_RESET;
        end else begin
            if (w_rx_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_go) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_command <= i_cfg_expected_command;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rx_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    pfp_frame_track u_frame_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (w_go),
        .i_byte    (r_in_byte),
        .i_command (r_command),
        .o_last    (w_last),
        .o_result  (w_next_result)
    );

    pfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_go && w_last),
        .i_result (w_next_result),
        .i_stall  (i_res_stall),
        .o_valid  (o_res_valid),
        .o_result (w_out_result)
    );

    assign o_pm_small       = w_out_result.pm_small;
    assign o_pm_large       = w_out_result.pm_large;
    assign o_frame_accepted = w_out_result.frame_accepted;

`ifndef SYNTHESIS
    a_result_from_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(w_go && w_last))
        else $error("result appeared without a frame-ending byte");

    a_in_reg_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_go) |=> r_in_valid && $stable(r_in_byte))
        else $error("held input byte was lost or overwritten");
`endif

endmodule

// File: rtl/pfp_frame_track.sv
module pfp_frame_track (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  logic [pfp_pkg::BYTE_W-1:0]        i_byte,
    input  logic [pfp_pkg::BYTE_W-1:0]        i_command,
    output logic                              o_last,
    output pfp_pkg::t_result                  o_result
);

    // Divide by ten as a multiply by ceil(2^19 / 10) and a shift; exact for 16-bit inputs.
    localparam logic [31:0] RECIP_10    = 32'd52429;
    localparam int          RECIP_SHIFT = 19;

    function automatic logic [pfp_pkg::READING_W-1:0] div_by_ten(
        input logic [pfp_pkg::RAW_W-1:0] raw
    );
        logic [31:0] prod;
        prod = 32'(raw) * RECIP_10;
        return prod[RECIP_SHIFT +: pfp_pkg::READING_W];
    endfunction

    pfp_pkg::t_pos                    r_pos,         n_pos;
    logic                             r_good,        n_good;
    logic [pfp_pkg::BYTE_W-1:0]       r_sum,         n_sum;
    logic [pfp_pkg::RAW_W-1:0]        r_raw_small,   n_raw_small;
    logic [pfp_pkg::RAW_W-1:0]        r_raw_large,   n_raw_large;
    logic [pfp_pkg::READING_W-1:0]    r_held_small,  n_held_small;
    logic [pfp_pkg::READING_W-1:0]    r_held_large,  n_held_large;
    logic                             w_accept;

    always_comb begin
        n_pos        = r_pos;
        n_good       = r_good;
        n_sum        = r_sum;
        n_raw_small  = r_raw_small;
        n_raw_large  = r_raw_large;
        n_held_small = r_held_small;
        n_held_large = r_held_large;

        o_last   = (r_pos >= pfp_pkg::POS_TAIL);
        w_accept = r_good && (i_byte == pfp_pkg::TAIL_BYTE);

        if ((r_pos >= pfp_pkg::POS_SMALL_LO) && (r_pos <= pfp_pkg::POS_SUM_LAST)) begin
            n_sum = r_sum + i_byte;
        end

        unique case (r_pos)
            pfp_pkg::POS_HEADER: begin
                if (i_byte != pfp_pkg::HEADER_BYTE) n_good = 1'b0;
            end
            pfp_pkg::POS_COMMAND: begin
                if (i_byte != i_command) n_good = 1'b0;
            end
            pfp_pkg::POS_SMALL_LO: n_raw_small = {r_raw_small[15:8], i_byte};
            pfp_pkg::POS_SMALL_HI: n_raw_small = {i_byte, r_raw_small[7:0]};
            pfp_pkg::POS_LARGE_LO: n_raw_large = {r_raw_large[15:8], i_byte};
            pfp_pkg::POS_LARGE_HI: n_raw_large = {i_byte, r_raw_large[7:0]};
            pfp_pkg::POS_CHECKSUM: begin
                if (i_byte != r_sum) n_good = 1'b0;
            end
            default: ;
        endcase

        if (o_last) begin
            if (w_accept) begin
                n_held_small = div_by_ten(r_raw_small);
                n_held_large = div_by_ten(r_raw_large);
            end
            n_pos       = pfp_pkg::POS_HEADER;
            n_good      = 1'b1;
            n_sum       = '0;
            n_raw_small = '0;
            n_raw_large = '0;
        end else begin
            n_pos = r_pos + 4'd1;
        end

        o_result.pm_small       = n_held_small;
        o_result.pm_large       = n_held_large;
        o_result.frame_accepted = w_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= pfp_pkg::POS_HEADER;
            r_good       <= 1'b1;
            r_sum        <= '0;
            r_raw_small  <= '0;
            r_raw_large  <= '0;
            r_held_small <= '0;
            r_held_large <= '0;
        end else if (i_go) begin
            r_pos        <= n_pos;
            r_good       <= n_good;
            r_sum        <= n_sum;
            r_raw_small  <= n_raw_small;
            r_raw_large  <= n_raw_large;
            r_held_small <= n_held_small;
            r_held_large <= n_held_large;
        end
    end

`ifndef SYNTHESIS
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= pfp_pkg::POS_TAIL)
        else $error("byte position left the frame");

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_last) |=> (r_pos == pfp_pkg::POS_HEADER) && r_good && (r_sum == '0))
        else $error("frame state not restarted after the last byte");

    a_held_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && !(o_last && w_accept)) |=> $stable(r_held_small) && $stable(r_held_large))
        else $error("held readings changed without an accepted frame");
`endif

endmodule

// File: rtl/pfp_out_reg.sv
module pfp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pfp_pkg::t_result  i_result,
    input  logic              i_stall,
    output logic              o_valid,
    output pfp_pkg::t_result  o_result
);

    logic             r_valid;
    pfp_pkg::t_result r_result;

    // Loads only happen when the register is empty or being taken this cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
